>>> rtl/mrna_codon_translator_unit_assert.svh
// Assertion macros for the codon translator.
`ifndef MRNA_CODON_TRANSLATOR_UNIT_ASSERT_SVH
`define MRNA_CODON_TRANSLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define MCTU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define MCTU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	`MCTU_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`else

`define MCTU_ASSERT(lbl, clk, rstn, prop, msg)

`define MCTU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/mct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

	// 2-bit base codes
	localparam logic [1:0] BASE_U = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_A = 2'd2;
	localparam logic [1:0] BASE_G = 2'd3;

	localparam logic [7:0] CHR_U = 8'h55;
	localparam logic [7:0] CHR_C = 8'h43;
	localparam logic [7:0] CHR_A = 8'h41;
	localparam logic [7:0] CHR_G = 8'h47;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [5:0] START_INDEX = 6'd35;   // AUG
	localparam logic [4:0] STOP_MARK = 5'd31;
	localparam logic [4:0] CODE_MET = 5'd12;
	localparam logic [1:0] PHASE_LAST = 2'd2;

	localparam logic [1:0] OUT_NOSTOP = 2'd0;
	localparam logic [1:0] OUT_RANOUT = 2'd1;
	localparam logic [1:0] OUT_NOSTART = 2'd2;

	// Standard genetic code, index = first*16 + second*4 + third (U C A G)
	localparam logic [4:0] GENE_CODE [0:63] = '{
		5'd13, 5'd13, 5'd10, 5'd10, 5'd15, 5'd15, 5'd15, 5'd15,
		5'd18, 5'd18, 5'd31, 5'd31, 5'd4,  5'd4,  5'd31, 5'd17,
		5'd10, 5'd10, 5'd10, 5'd10, 5'd14, 5'd14, 5'd14, 5'd14,
		5'd8,  5'd8,  5'd5,  5'd5,  5'd1,  5'd1,  5'd1,  5'd1,
		5'd9,  5'd9,  5'd9,  5'd12, 5'd16, 5'd16, 5'd16, 5'd16,
		5'd2,  5'd2,  5'd11, 5'd11, 5'd15, 5'd15, 5'd1,  5'd1,
		5'd19, 5'd19, 5'd19, 5'd19, 5'd0,  5'd0,  5'd0,  5'd0,
		5'd3,  5'd3,  5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd7
	};

	typedef enum logic [2:0] {
		MODE_AWAIT = 3'b001,
		MODE_RUN   = 3'b010,
		MODE_DONE  = 3'b100
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] phase;
		logic [3:0] held;
	} scan_state_t;

	typedef struct packed {
		logic       emit;
		logic       amino_valid;
		logic [4:0] amino_code;
		logic       last;
		logic [1:0] outcome;
	} result_t;

	localparam scan_state_t STATE_RESET = '{mode: MODE_AWAIT, phase: 2'd0, held: 4'd0};

endpackage

`default_nettype wire

>>> rtl/mct_codon_step.sv
`timescale 1ns / 1ps
`default_nettype none

module mct_codon_step (
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_text,
	input  wire mct_pkg::scan_state_t cur,
	output mct_pkg::scan_state_t     nxt,
	output mct_pkg::result_t         res
);

	logic       is_base;
	logic [1:0] base;
	logic [7:0] upper;
	logic       active;
	logic [5:0] idx;
	logic [4:0] code;

	always_comb begin
		// fold lower case onto upper case
		upper = text_byte;
		if (text_byte >= 8'h61 && text_byte <= 8'h7a) begin
			upper = text_byte & ~mct_pkg::CASE_BIT;
		end
		is_base = 1'b1;
		base = mct_pkg::BASE_U;
		unique case (upper)
			mct_pkg::CHR_U: base = mct_pkg::BASE_U;
			mct_pkg::CHR_C: base = mct_pkg::BASE_C;
			mct_pkg::CHR_A: base = mct_pkg::BASE_A;
			mct_pkg::CHR_G: base = mct_pkg::BASE_G;
			default: is_base = 1'b0;
		endcase
	end

	always_comb begin
		unique case (cur.mode)
			mct_pkg::MODE_AWAIT, mct_pkg::MODE_RUN: active = 1'b1;
			default: active = 1'b0;
		endcase
	end

	assign idx = {cur.held, base};
	assign code = mct_pkg::GENE_CODE[idx];

	always_comb begin
		nxt = cur;
		res = '0;
		if (is_base && active) begin
			if (cur.phase < mct_pkg::PHASE_LAST) begin
				nxt.held = {cur.held[1:0], base};
				nxt.phase = cur.phase + 2'd1;
			end else begin
				nxt.phase = 2'd0;
				nxt.held = 4'd0;
				res.emit = 1'b1;
				res.last = 1'b1;
				if (cur.mode == mct_pkg::MODE_AWAIT && idx != mct_pkg::START_INDEX) begin
					res.outcome = mct_pkg::OUT_NOSTART;
					nxt.mode = mct_pkg::MODE_DONE;
				end else if (code == mct_pkg::STOP_MARK) begin
					res.outcome = mct_pkg::OUT_NOSTOP;
					nxt.mode = mct_pkg::MODE_DONE;
				end else begin
					res.amino_valid = 1'b1;
					res.amino_code = code;
					res.last = end_of_text;
					res.outcome = end_of_text ? mct_pkg::OUT_RANOUT : mct_pkg::OUT_NOSTOP;
					nxt.mode = mct_pkg::MODE_RUN;
				end
			end
		end
		if (end_of_text) begin
			// close the sequence if nothing was reported yet
			if (!res.emit) begin
				if (cur.mode == mct_pkg::MODE_AWAIT) begin
					res.emit = 1'b1;
					res.last = 1'b1;
					res.outcome = mct_pkg::OUT_NOSTART;
				end else if (cur.mode == mct_pkg::MODE_RUN) begin
					res.emit = 1'b1;
					res.last = 1'b1;
					res.outcome = mct_pkg::OUT_RANOUT;
				end
			end
			nxt = mct_pkg::STATE_RESET;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mrna_codon_translator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mrna_codon_translator_unit_assert.svh"
// Throughput: one text byte per cycle; input register, codon step logic and
// output register form a two-stage pipeline that stalls only on m_axis_tready.
// Reset: arst_n clears the pipeline valids and the codon state (awaiting AUG,
// no bases held); data registers are not reset.

module mrna_codon_translator_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
	input  wire logic       s_axis_tlast,   // end_of_text
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [4:0] amino_code, [6:5] outcome, [7] zero
	output logic            m_axis_tuser,   // [0] amino_valid
	output logic            m_axis_tlast    // last
);

	logic                 advance;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	mct_pkg::scan_state_t state_q;
	mct_pkg::scan_state_t state_nxt;
	mct_pkg::result_t     res;
	logic                 valid_s2;
	logic [4:0]           code_s2;
	logic [1:0]           outcome_s2;
	logic                 amino_s2;
	logic                 last_s2;

	// move both stages whenever the output slot is free or being drained
	assign advance = !valid_s2 || m_axis_tready;
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	mct_codon_step u_step (
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mct_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res.emit;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_s2 <= res.amino_code;
			outcome_s2 <= res.outcome;
			amino_s2 <= res.amino_valid;
			last_s2 <= res.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {1'b0, outcome_s2, code_s2};
	assign m_axis_tuser = amino_s2;
	assign m_axis_tlast = last_s2;

	`MCTU_ASSERT_IMPL(a_result_has_meaning, clk, arst_n, m_axis_tvalid, m_axis_tuser || m_axis_tlast, "result carries neither amino acid nor end")
	`MCTU_ASSERT_IMPL(a_outcome_only_on_last, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[6:5] == mct_pkg::OUT_NOSTOP, "outcome set on a non-final result")
	`MCTU_ASSERT_IMPL(a_end_clears_state, clk, arst_n, advance && valid_s1 && last_s1, ##1 (state_q == mct_pkg::STATE_RESET), "state not cleared after end of text")
	`MCTU_ASSERT_IMPL(a_rose_needs_item, clk, arst_n, $rose(m_axis_tvalid), $past(valid_s1), "result appeared without a request in stage one")

endmodule

`default_nettype wire
